// ===== rtl/core/stepper_position_controller_top_defines.svh =====
// Assertion macros shared by the stepper position controller checkers.
// Each macro expands to one labeled concurrent assertion clocked on clk with rst_n.
`ifndef STEPPER_POSITION_CONTROLLER_TOP_DEFINES_SVH
`define STEPPER_POSITION_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication.
`define SPC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/spc_pkg.sv =====
// Package for the stepper position controller: widths, codes, types and helpers.
// Used by the channel interfaces and the top level.
package spc_pkg;

  localparam int POSITION_WIDTH  = 16;
  localparam int MICROSTEP_WIDTH = 8;

  localparam int FIELD_W   = 16;
  localparam int MPS_W     = 8;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int MS_CMP_W  = (MICROSTEP_WIDTH + 1 > MPS_W) ? MICROSTEP_WIDTH + 1 : MPS_W;

  localparam logic [OP_W-1:0] OP_SET_TARGET = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK       = 2'd1;
  localparam logic [OP_W-1:0] OP_REZERO     = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP        = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_POSITION   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MICROSTEPS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_STOP_EN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_STOP_EN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_STOP_POS = 3'd4;

  localparam logic [FIELD_W-1:0] MAX_POSITION_RST   = 16'd4096;
  localparam logic [MPS_W-1:0]   MICROSTEPS_RST     = 8'd1;
  localparam logic [FIELD_W-1:0] FRONT_STOP_POS_RST = 16'd4096;

  typedef logic [POSITION_WIDTH-1:0]  pos_t;
  typedef logic [MICROSTEP_WIDTH-1:0] ms_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [FIELD_W-1:0] target;
    logic               front_stop;
    logic               back_stop;
  } spc_item_t;

  typedef struct packed {
    logic               step_pulse;
    logic               direction;
    logic [FIELD_W-1:0] position;
    logic [FIELD_W-1:0] target_now;
    logic               busy_res;
    logic               stop_hit;
    logic               rejected;
  } spc_result_t;

  function automatic pos_t field_to_pos(logic [FIELD_W-1:0] v);
    logic [POSITION_WIDTH+FIELD_W-1:0] t;
    t = {{POSITION_WIDTH{1'b0}}, v};
    return t[POSITION_WIDTH-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] pos_to_field(pos_t p);
    logic [POSITION_WIDTH+FIELD_W-1:0] t;
    t = {{FIELD_W{1'b0}}, p};
    return t[FIELD_W-1:0];
  endfunction

endpackage

// ===== rtl/core/spc_if.sv =====
// Valid/ready channel interfaces of the stepper position controller.
// Depends on spc_pkg for field widths.
interface spc_in_if;
  logic                          valid;
  logic                          ready;
  logic [spc_pkg::OP_W-1:0]      op;
  logic [spc_pkg::FIELD_W-1:0]   target;
  logic                          front_stop;
  logic                          back_stop;
  modport source (output valid, op, target, front_stop, back_stop, input ready);
  modport sink   (input valid, op, target, front_stop, back_stop, output ready);
endinterface

interface spc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          step_pulse;
  logic                          direction;
  logic [spc_pkg::FIELD_W-1:0]   position;
  logic [spc_pkg::FIELD_W-1:0]   target_now;
  logic                          busy_res;
  logic                          stop_hit;
  logic                          rejected;
  modport source (output valid, step_pulse, direction, position, target_now, busy_res,
                  stop_hit, rejected, input ready);
  modport sink   (input valid, step_pulse, direction, position, target_now, busy_res,
                  stop_hit, rejected, output ready);
endinterface

interface spc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [spc_pkg::CFG_IDX_W-1:0] index;
  logic [spc_pkg::CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/stepper_position_controller_top.sv =====
// Stepper position controller top level: input register, command logic, result register.
// Depends on spc_pkg and the channel interfaces in spc_if.sv.
//
// Usage: in_if carries one command per beat (set target, tick one microstep, rezero,
// no operation) together with the two end stop levels. Every accepted beat yields
// exactly one beat on out_if with the pulse, direction, positions and status flags.
// cfg_if writes the five configuration registers by index; it is always ready and
// is meant to be written while the block is idle.
// A beat accepted into the input register has its result computed combinationally and
// loaded into the output register whenever the output register is free to advance.
// Throughput is one beat per cycle unless the receiver stalls, set by the single pass
// of compare, increment and select logic between position state and output register.
// When the receiver stalls, the result is held and the input register still takes
// one more beat; in_if.ready drops only when both registers are full.
// Reset clears both valid flags, loads the configuration defaults and sets target
// and actual position to half the default maximum with the microstep count cleared.
module stepper_position_controller_top (
  input  logic clk,
  input  logic rst_n,
  spc_in_if.sink    in_if,
  spc_out_if.source out_if,
  spc_cfg_if.sink   cfg_if
);
  import spc_pkg::*;

  localparam pos_t POS_RST  = field_to_pos(MAX_POSITION_RST >> 1);
  localparam pos_t POS_ONES = '1;

  logic [FIELD_W-1:0] max_pos_r;
  logic [MPS_W-1:0]   mps_r;
  logic               front_en_r;
  logic               back_en_r;
  logic [FIELD_W-1:0] front_pos_r;

  pos_t act_r, act_nxt;
  pos_t tgt_r, tgt_nxt;
  ms_t  ms_r, ms_nxt;
  logic dir_r, dir_nxt;

  spc_item_t   item_r;
  logic        item_valid_r;
  spc_result_t res_r, res_nxt;
  logic        res_valid_r;

  logic advance;
  logic busy_now;
  logic dir_eff;
  logic [MICROSTEP_WIDTH:0] ms_inc;
  logic [MS_CMP_W-1:0] per_cmp;
  logic [MS_CMP_W-1:0] inc_cmp;
  logic step_done;
  logic pulse, hit, rej;

  assign advance     = !res_valid_r || out_if.ready;
  assign in_if.ready = !item_valid_r || advance;
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_pos_r   <= MAX_POSITION_RST;
      mps_r       <= MICROSTEPS_RST;
      front_en_r  <= 1'b0;
      back_en_r   <= 1'b0;
      front_pos_r <= FRONT_STOP_POS_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_MAX_POSITION:   max_pos_r   <= cfg_if.data;
        REG_MICROSTEPS:     mps_r       <= cfg_if.data[MPS_W-1:0];
        REG_FRONT_STOP_EN:  front_en_r  <= cfg_if.data[0];
        REG_BACK_STOP_EN:   back_en_r   <= cfg_if.data[0];
        REG_FRONT_STOP_POS: front_pos_r <= cfg_if.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    act_nxt = act_r;
    tgt_nxt = tgt_r;
    ms_nxt  = ms_r;
    dir_nxt = dir_r;
    pulse   = 1'b0;
    hit     = 1'b0;
    rej     = 1'b0;
    busy_now = (act_r != tgt_r) || (ms_r != '0);
    dir_eff = (ms_r == '0) ? !(act_r < tgt_r) : dir_r;
    ms_inc  = {1'b0, ms_r} + 1'b1;
    per_cmp = (mps_r == '0) ? MS_CMP_W'(1) : MS_CMP_W'(mps_r);
    inc_cmp = MS_CMP_W'(ms_inc);
    step_done = (inc_cmp >= per_cmp) || ms_inc[MICROSTEP_WIDTH];
    case (item_r.op)
      OP_SET_TARGET: begin
        if (item_r.target > max_pos_r) begin
          rej = 1'b1;
        end else begin
          tgt_nxt = field_to_pos(item_r.target);
        end
      end
      OP_TICK: begin
        if (busy_now) begin
          dir_nxt = dir_eff;
          if (!dir_eff && front_en_r && item_r.front_stop) begin
            act_nxt = field_to_pos(front_pos_r);
            ms_nxt  = '0;
            hit     = 1'b1;
          end else if (dir_eff && back_en_r && item_r.back_stop) begin
            act_nxt = '0;
            ms_nxt  = '0;
            hit     = 1'b1;
          end else begin
            pulse = 1'b1;
            if (step_done) begin
              ms_nxt = '0;
              if (!dir_eff) begin
                if (act_r != POS_ONES) begin
                  act_nxt = act_r + 1'b1;
                end
              end else if (act_r != '0) begin
                act_nxt = act_r - 1'b1;
              end
            end else begin
              ms_nxt = ms_inc[MICROSTEP_WIDTH-1:0];
            end
          end
        end
      end
      OP_REZERO: begin
        act_nxt = field_to_pos(max_pos_r >> 1);
        tgt_nxt = field_to_pos(max_pos_r >> 1);
        ms_nxt  = '0;
      end
      default: ;
    endcase
    res_nxt.step_pulse = pulse;
    res_nxt.direction  = dir_nxt;
    res_nxt.position   = pos_to_field(act_nxt);
    res_nxt.target_now = pos_to_field(tgt_nxt);
    res_nxt.busy_res   = (act_nxt != tgt_nxt) || (ms_nxt != '0);
    res_nxt.stop_hit   = hit;
    res_nxt.rejected   = rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      res_valid_r  <= 1'b0;
      act_r        <= POS_RST;
      tgt_r        <= POS_RST;
      ms_r         <= '0;
      dir_r        <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        item_valid_r <= 1'b1;
      end else if (advance) begin
        item_valid_r <= 1'b0;
      end
      if (advance) begin
        res_valid_r <= item_valid_r;
      end
      if (advance && item_valid_r) begin
        act_r <= act_nxt;
        tgt_r <= tgt_nxt;
        ms_r  <= ms_nxt;
        dir_r <= dir_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      item_r.op         <= in_if.op;
      item_r.target     <= in_if.target;
      item_r.front_stop <= in_if.front_stop;
      item_r.back_stop  <= in_if.back_stop;
    end
    if (advance && item_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_if.valid      = res_valid_r;
  assign out_if.step_pulse = res_r.step_pulse;
  assign out_if.direction  = res_r.direction;
  assign out_if.position   = res_r.position;
  assign out_if.target_now = res_r.target_now;
  assign out_if.busy_res   = res_r.busy_res;
  assign out_if.stop_hit   = res_r.stop_hit;
  assign out_if.rejected   = res_r.rejected;

endmodule

// ===== rtl/core/spc_checker.sv =====
// Port-level checker for the stepper position controller, bound to the top level.
// Depends on the assertion macros in stepper_position_controller_top_defines.svh.
`include "stepper_position_controller_top_defines.svh"

module spc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        step_pulse,
  input logic        busy_res,
  input logic        stop_hit,
  input logic        rejected,
  input logic [15:0] position,
  input logic [15:0] target_now
);

  `SPC_ASSERT_IMPL(a_pulse_or_hit, out_valid, !(step_pulse && stop_hit), "pulse and stop hit together")
  `SPC_ASSERT_IMPL(a_reject_no_motion, out_valid && rejected, !step_pulse && !stop_hit, "rejected beat reports motion")
  `SPC_ASSERT_IMPL(a_idle_at_target, out_valid && !busy_res, position == target_now, "idle with position off target")
  `SPC_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(position) && $stable(target_now), "stalled result changed")

endmodule

bind stepper_position_controller_top spc_checker u_spc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .step_pulse (out_if.step_pulse),
  .busy_res   (out_if.busy_res),
  .stop_hit   (out_if.stop_hit),
  .rejected   (out_if.rejected),
  .position   (out_if.position),
  .target_now (out_if.target_now)
);

// ===== verif/stepper_position_controller_checker.sv =====
`timescale 1ns / 100ps
// Checker for the stepper position controller: keeps its own copy of the motor state and
// configuration, predicts one result per accepted input beat and compares every output beat.
// Depends on spc_pkg and the channel interfaces in spc_if.sv.
module stepper_position_controller_checker (
  input  logic clk,
  input  logic rst_n,
  spc_in_if    in_ch,
  spc_out_if   out_ch,
  spc_cfg_if   cfg_ch,
  output int   errors,
  output int   pending,
  output int   pulses,
  output int   stop_hits,
  output int   rejects
);
  import spc_pkg::*;

  localparam logic DIR_UP   = 1'b0;
  localparam logic DIR_DOWN = 1'b1;

  logic [FIELD_W-1:0] max_pos;
  logic [MPS_W-1:0]   usteps_per_step;
  logic               front_en;
  logic               back_en;
  logic [FIELD_W-1:0] front_pos;

  pos_t act_pos;
  pos_t tgt_pos;
  ms_t  ustep;
  logic dir;

  spc_result_t motion_q[$];

  function automatic spc_result_t step_motor(spc_item_t c);
    spc_result_t r;
    int per;
    int nxt;
    r = '0;
    case (c.op)
      OP_SET_TARGET: begin
        if (c.target > max_pos) r.rejected = 1'b1;
        else tgt_pos = c.target;
      end
      OP_TICK: begin
        if (act_pos != tgt_pos || ustep != 0) begin
          if (ustep == 0) dir = (act_pos < tgt_pos) ? DIR_UP : DIR_DOWN;
          if (dir == DIR_UP && front_en && c.front_stop) begin
            act_pos = front_pos;
            ustep = '0;
            r.stop_hit = 1'b1;
          end else if (dir == DIR_DOWN && back_en && c.back_stop) begin
            act_pos = '0;
            ustep = '0;
            r.stop_hit = 1'b1;
          end else begin
            per = (usteps_per_step == 0) ? 1 : int'(usteps_per_step);
            nxt = int'(ustep) + 1;
            r.step_pulse = 1'b1;
            if (nxt >= per || nxt > (1 << MICROSTEP_WIDTH) - 1) begin
              ustep = '0;
              if (dir == DIR_UP) begin
                if (act_pos != '1) act_pos = act_pos + 1'b1;
              end else begin
                if (act_pos != '0) act_pos = act_pos - 1'b1;
              end
            end else begin
              ustep = nxt[MICROSTEP_WIDTH-1:0];
            end
          end
        end
      end
      OP_REZERO: begin
        act_pos = max_pos >> 1;
        tgt_pos = max_pos >> 1;
        ustep = '0;
      end
      default: ;
    endcase
    r.direction  = dir;
    r.position   = act_pos;
    r.target_now = tgt_pos;
    r.busy_res   = (act_pos != tgt_pos) || (ustep != 0);
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    spc_item_t   item;
    spc_result_t want;
    spc_result_t got;
    if (!rst_n) begin
      max_pos = MAX_POSITION_RST;
      usteps_per_step = MICROSTEPS_RST;
      front_en = 1'b0;
      back_en = 1'b0;
      front_pos = FRONT_STOP_POS_RST;
      act_pos = MAX_POSITION_RST >> 1;
      tgt_pos = MAX_POSITION_RST >> 1;
      ustep = '0;
      dir = DIR_UP;
      motion_q.delete();
      errors = 0;
      pulses = 0;
      stop_hits = 0;
      rejects = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_MAX_POSITION:   max_pos = cfg_ch.data;
          REG_MICROSTEPS:     usteps_per_step = cfg_ch.data[MPS_W-1:0];
          REG_FRONT_STOP_EN:  front_en = cfg_ch.data[0];
          REG_BACK_STOP_EN:   back_en = cfg_ch.data[0];
          REG_FRONT_STOP_POS: front_pos = cfg_ch.data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got.step_pulse = out_ch.step_pulse;
        got.direction  = out_ch.direction;
        got.position   = out_ch.position;
        got.target_now = out_ch.target_now;
        got.busy_res   = out_ch.busy_res;
        got.stop_hit   = out_ch.stop_hit;
        got.rejected   = out_ch.rejected;
        if (motion_q.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, actual %h", $time, got);
        end else begin
          want = motion_q.pop_front();
          check_field("step_pulse", int'(want.step_pulse), int'(got.step_pulse));
          check_field("direction", int'(want.direction), int'(got.direction));
          check_field("position", int'(want.position), int'(got.position));
          check_field("target_now", int'(want.target_now), int'(got.target_now));
          check_field("busy_res", int'(want.busy_res), int'(got.busy_res));
          check_field("stop_hit", int'(want.stop_hit), int'(got.stop_hit));
          check_field("rejected", int'(want.rejected), int'(got.rejected));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        item.op = in_ch.op;
        item.target = in_ch.target;
        item.front_stop = in_ch.front_stop;
        item.back_stop = in_ch.back_stop;
        want = step_motor(item);
        motion_q.push_back(want);
        pulses += int'(want.step_pulse);
        stop_hits += int'(want.stop_hit);
        rejects += int'(want.rejected);
      end
    end
    pending = motion_q.size();
  end

endmodule

// ===== verif/stepper_position_controller_top_test.sv =====
`timescale 1ns / 100ps
// Testbench top for the stepper position controller: clock, reset, command and register
// stimulus with random idling and back pressure, and the final verdict.
// Depends on spc_pkg, spc_if.sv, the block and stepper_position_controller_checker.
module stepper_position_controller_top_test;
  import spc_pkg::*;

  typedef struct {
    logic [FIELD_W-1:0] max_pos;
    logic [MPS_W-1:0]   usteps;
    logic               front_en;
    logic               back_en;
    logic [FIELD_W-1:0] front_pos;
  } motor_setup_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   in_gaps = 1'b1;
  bit   out_gaps = 1'b1;
  int   hold_requests = 0;
  int   errors;
  int   pending;
  int   pulses;
  int   stop_hits;
  int   rejects;
  int   commands_sent = 0;
  int   setups_run = 0;

  spc_in_if  in_ch ();
  spc_out_if out_ch ();
  spc_cfg_if cfg_ch ();

  stepper_position_controller_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  stepper_position_controller_checker motion_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_ch    (cfg_ch),
    .errors    (errors),
    .pending   (pending),
    .pulses    (pulses),
    .stop_hits (stop_hits),
    .rejects   (rejects)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // The receiver counts a requested hold-off itself, so the sender keeps offering beats.
  initial begin
    int hold_left;
    int holds_served;
    hold_left = 0;
    holds_served = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        hold_left = 60;
        holds_served = hold_requests;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= !(out_gaps && $urandom_range(99) < 20);
      end
    end
  end

  function automatic spc_item_t cmd(logic [OP_W-1:0] op, logic [FIELD_W-1:0] target,
                                    logic fs, logic bs);
    spc_item_t c;
    c.op = op;
    c.target = target;
    c.front_stop = fs;
    c.back_stop = bs;
    return c;
  endfunction

  function automatic logic [FIELD_W-1:0] pick_target(logic [FIELD_W-1:0] max_pos);
    int sel;
    int t;
    sel = $urandom_range(99);
    if (sel < 50) return FIELD_W'($urandom_range(max_pos));
    if (sel < 85) begin
      t = $urandom_range(16);
      t = int'(max_pos >> 1) + t - 8;
      if (t < 0) t = 0;
      if (t > int'(max_pos)) t = int'(max_pos);
      return t[FIELD_W-1:0];
    end
    return FIELD_W'($urandom_range(16'hFFFF));
  endfunction

  function automatic spc_item_t random_cmd(logic [FIELD_W-1:0] max_pos);
    spc_item_t c;
    int sel;
    sel = $urandom_range(99);
    c.target = FIELD_W'($urandom_range(16'hFFFF));
    c.front_stop = ($urandom_range(99) < 15);
    c.back_stop = ($urandom_range(99) < 15);
    if (sel < 62) begin
      c.op = OP_TICK;
    end else if (sel < 88) begin
      c.op = OP_SET_TARGET;
      c.target = pick_target(max_pos);
    end else if (sel < 96) begin
      c.op = OP_REZERO;
    end else begin
      c.op = OP_NOP;
    end
    return c;
  endfunction

  task automatic send_cmd(input spc_item_t c);
    @(negedge clk);
    while (in_gaps && $urandom_range(99) < 20) begin
      in_ch.valid <= 1'b0;
      in_ch.target <= FIELD_W'($urandom_range(16'hFFFF));
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= c.op;
    in_ch.target <= c.target;
    in_ch.front_stop <= c.front_stop;
    in_ch.back_stop <= c.back_stop;
    commands_sent++;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic load_setup(input motor_setup_t s);
    logic [CFG_IDX_W-1:0] idx [5];
    logic [CFG_DAT_W-1:0] vals [5];
    idx = '{REG_MAX_POSITION, REG_MICROSTEPS, REG_FRONT_STOP_EN, REG_BACK_STOP_EN,
            REG_FRONT_STOP_POS};
    vals[0] = s.max_pos;
    vals[1] = CFG_DAT_W'(s.usteps);
    vals[2] = CFG_DAT_W'(s.front_en);
    vals[3] = CFG_DAT_W'(s.back_en);
    vals[4] = s.front_pos;
    for (int i = 0; i < 5; i++) begin
      @(negedge clk);
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data <= vals[i];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    setups_run++;
  endtask

  initial begin
    motor_setup_t s;
    motor_setup_t plan [7];
    in_ch.valid = 1'b0;
    in_ch.op = OP_NOP;
    in_ch.target = '0;
    in_ch.front_stop = 1'b0;
    in_ch.back_stop = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_MAX_POSITION;
    cfg_ch.data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: idle tick, range checks on the target, a short move and a rezero.
    send_cmd(cmd(OP_TICK, 16'd0, 1'b1, 1'b1));
    send_cmd(cmd(OP_SET_TARGET, 16'd4097, 1'b0, 1'b0));
    send_cmd(cmd(OP_SET_TARGET, 16'hFFFF, 1'b0, 1'b0));
    send_cmd(cmd(OP_SET_TARGET, 16'd4096, 1'b0, 1'b0));
    send_cmd(cmd(OP_SET_TARGET, 16'd0, 1'b0, 1'b0));
    send_cmd(cmd(OP_SET_TARGET, 16'd2050, 1'b1, 1'b0));
    send_cmd(cmd(OP_TICK, 16'd0, 1'b1, 1'b0));
    send_cmd(cmd(OP_TICK, 16'd0, 1'b0, 1'b1));
    send_cmd(cmd(OP_TICK, 16'd0, 1'b0, 1'b0));
    send_cmd(cmd(OP_NOP, 16'hFFFF, 1'b1, 1'b1));
    send_cmd(cmd(OP_REZERO, 16'd0, 1'b1, 1'b1));
    wait_idle();

    // Both end stops, full range, and a target change in the middle of a step.
    s = '{16'hFFFF, 8'd3, 1'b1, 1'b1, 16'hFFFF};
    load_setup(s);
    send_cmd(cmd(OP_SET_TARGET, 16'hFFFF, 1'b0, 1'b0));
    send_cmd(cmd(OP_TICK, 16'd0, 1'b1, 1'b0));
    send_cmd(cmd(OP_SET_TARGET, 16'd0, 1'b0, 1'b0));
    send_cmd(cmd(OP_TICK, 16'd0, 1'b1, 1'b1));
    send_cmd(cmd(OP_SET_TARGET, 16'd1, 1'b0, 1'b0));
    send_cmd(cmd(OP_TICK, 16'd0, 1'b0, 1'b1));
    send_cmd(cmd(OP_SET_TARGET, 16'd0, 1'b0, 1'b0));
    send_cmd(cmd(OP_TICK, 16'd0, 1'b0, 1'b0));
    send_cmd(cmd(OP_TICK, 16'd0, 1'b0, 1'b0));
    send_cmd(cmd(OP_TICK, 16'd0, 1'b0, 1'b0));
    wait_idle();

    // A zero maximum accepts only target zero and rezeroes to zero.
    s = '{16'd0, 8'd1, 1'b0, 1'b0, 16'd0};
    load_setup(s);
    send_cmd(cmd(OP_REZERO, 16'd0, 1'b0, 1'b0));
    send_cmd(cmd(OP_SET_TARGET, 16'd0, 1'b0, 1'b0));
    send_cmd(cmd(OP_SET_TARGET, 16'd1, 1'b0, 1'b0));
    wait_idle();

    plan[0] = '{16'd16, 8'd1, 1'b0, 1'b0, 16'd16};
    plan[1] = '{16'd40, 8'd3, 1'b1, 1'b1, 16'd40};
    plan[2] = '{16'hFFFF, 8'd0, 1'b1, 1'b0, 16'd0};
    plan[3] = '{16'd1, 8'd2, 1'b0, 1'b1, 16'hFFFF};
    plan[4] = '{16'd300, 8'd255, 1'b1, 1'b1, 16'd300};
    for (int k = 5; k < 7; k++) begin
      plan[k].max_pos = FIELD_W'($urandom_range(64, 1));
      plan[k].usteps = MPS_W'($urandom_range(5));
      plan[k].front_en = 1'($urandom_range(1));
      plan[k].back_en = 1'($urandom_range(1));
      plan[k].front_pos = FIELD_W'($urandom_range(16'hFFFF));
    end

    for (int p = 0; p < 7; p++) begin
      load_setup(plan[p]);
      in_gaps = (p != 2);
      out_gaps = (p != 2);
      for (int i = 0; i < 215; i++) begin
        if (p == 1 && i == 100) hold_requests++;
        if (p == 3 && i == 100) wait_idle();
        send_cmd(random_cmd(plan[p].max_pos));
      end
      wait_idle();
    end

    $display("Ran %0d commands under %0d register settings, directed cases then random.",
             commands_sent, setups_run);
    $display("Checked %0d step pulses, %0d end stop aborts and %0d rejected targets.",
             pulses, stop_hits, rejects);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
